### design/kcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcc_pkg
// Shared types, keyword table and category codes for the keyword category
// classifier.
// ----------------------------------------------------------------------------
package kcc_pkg;

	localparam int MATCH_WINDOW_DEFAULT = 10;
	localparam int KW_MAX               = 10;
	localparam int KW_COUNT             = 26;
	localparam int GROUP_COUNT          = 6;

	localparam logic [2:0] CAT_INSTRUMENT = 3'd0;
	localparam logic [2:0] CAT_OTHER      = 3'd6;

	typedef logic [7:0] byte_t;
	typedef logic [GROUP_COUNT-1:0] hits_t;

	// text right-aligned: the last character of a keyword sits in bits [7:0]
	localparam logic [KW_MAX*8-1:0] KW_TEXT [KW_COUNT] = '{
		"instrument", "generator", "synth", "sampler",
		"delay", "reverb", "echo",
		"distortion", "guitar", "bass", "drive", "saturat", "amp",
		"dynamics", "compressor", "comp", "limiter", "gate",
		"eq", "filter", "equalizer",
		"modulation", "chorus", "flanger", "phaser", "tremolo"
	};

	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd10, 4'd9, 4'd5, 4'd7,
		4'd5, 4'd6, 4'd4,
		4'd10, 4'd6, 4'd4, 4'd5, 4'd7, 4'd3,
		4'd8, 4'd10, 4'd4, 4'd7, 4'd4,
		4'd2, 4'd6, 4'd9,
		4'd10, 4'd6, 4'd7, 4'd6, 4'd7
	};

	localparam logic [2:0] KW_GROUP [KW_COUNT] = '{
		3'd0, 3'd0, 3'd0, 3'd0,
		3'd1, 3'd1, 3'd1,
		3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
		3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
		3'd4, 3'd4, 3'd4,
		3'd5, 3'd5, 3'd5, 3'd5, 3'd5
	};

	// transaction handed from the front to the back
	typedef struct packed {
		logic       push;
		logic [2:0] category;
	} kcc_push_t;

	function automatic logic [2:0] pick_category(input hits_t hits, input logic inst);
		logic [2:0] cat;
		cat = CAT_OTHER;
		for (int g = GROUP_COUNT - 1; g >= 1; g--) begin
			if (hits[g]) begin
				cat = 3'(g);
			end
		end
		if (inst || hits[0]) begin
			cat = CAT_INSTRUMENT;
		end
		return cat;
	endfunction

endpackage

### design/kcc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcc_front
// Folds each byte, keeps the recent-byte window, matches all keywords in
// parallel and keeps the sticky group hits; pushes a category on the final byte.
// ----------------------------------------------------------------------------
module kcc_front #(
	parameter int MATCH_WINDOW = kcc_pkg::MATCH_WINDOW_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [7:0]        char_byte,
	input  logic              is_instrument,
	input  logic              end_of_string,
	input  logic              full,
	output kcc_pkg::kcc_push_t push
);
	import kcc_pkg::*;

	byte_t window_q [MATCH_WINDOW-1];
	hits_t hits_q;
	logic  inst_q;

	logic  accept;
	byte_t folded;
	byte_t recent [MATCH_WINDOW];
	hits_t hits_new;
	logic  inst_new;

	assign accept = in_valid && !full;

	always_comb begin
		folded = (char_byte >= 8'h41 && char_byte <= 8'h5a) ? char_byte + 8'd32 : char_byte;
		recent[0] = folded;
		for (int i = 1; i < MATCH_WINDOW; i++) begin
			recent[i] = window_q[i-1];
		end
	end

	// parallel keyword compare
	always_comb begin
		logic hit;
		hits_new = hits_q;
		for (int k = 0; k < KW_COUNT; k++) begin
			hit = (int'(KW_LEN[k]) <= MATCH_WINDOW);
			for (int i = 0; i < KW_MAX; i++) begin
				if (4'(i) < KW_LEN[k] && recent[i] != KW_TEXT[k][8*i +: 8]) begin
					hit = 1'b0;
				end
			end
			if (hit) begin
				hits_new[KW_GROUP[k]] = 1'b1;
			end
		end
		inst_new = inst_q || is_instrument;
	end

	assign push.push     = accept && end_of_string;
	assign push.category = pick_category(hits_new, inst_new);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q <= '0;
			inst_q <= 1'b0;
			for (int i = 0; i < MATCH_WINDOW - 1; i++) begin
				window_q[i] <= '0;
			end
		end else if (accept) begin
			if (end_of_string) begin
				hits_q <= '0;
				inst_q <= 1'b0;
				for (int i = 0; i < MATCH_WINDOW - 1; i++) begin
					window_q[i] <= '0;
				end
			end else begin
				hits_q <= hits_new;
				inst_q <= inst_new;
				for (int i = 0; i < MATCH_WINDOW - 1; i++) begin
					window_q[i] <= recent[i];
				end
			end
		end
	end

endmodule

### design/kcc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcc_back
// Two-entry result queue: an output register backed by a skid register.
// ----------------------------------------------------------------------------
module kcc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  kcc_pkg::kcc_push_t push,
	output logic               full,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         category
);
	import kcc_pkg::*;

	logic       out_valid_q;
	logic [2:0] out_cat_q;
	logic       skid_valid_q;
	logic [2:0] skid_cat_q;
	logic       pop;

	assign pop       = out_valid_q && !out_stall;
	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign category  = out_cat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push.push;
			end
		end else if (push.push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			out_cat_q <= skid_valid_q ? skid_cat_q : push.category;
		end else if (push.push) begin
			skid_cat_q <= push.category;
		end
	end

endmodule

### design/keyword_category_classifier_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyword_category_classifier_core
// Byte-stream keyword classifier: gives one category code per string.
// ----------------------------------------------------------------------------
// channel | direction | handshake             | payload
// input   | in        | in_valid / in_stall   | char_byte, is_instrument, end_of_string
// output  | out       | out_valid / out_stall | category
//
// one byte per cycle unless stalled; all keyword compares run in parallel in the front
// a category is registered in the result queue when its final byte is taken
// reset clears the window, group hits, instrument latch and result queue
// in_stall rises only when both result queue entries are occupied
// ----------------------------------------------------------------------------
module keyword_category_classifier_core #(
	parameter int MATCH_WINDOW = kcc_pkg::MATCH_WINDOW_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_byte,
	input  logic       is_instrument,
	input  logic       end_of_string,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] category
);
	import kcc_pkg::*;

	kcc_push_t push;
	logic      full;

	assign in_stall = full;

	kcc_front #(
		.MATCH_WINDOW(MATCH_WINDOW)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.char_byte    (char_byte),
		.is_instrument(is_instrument),
		.end_of_string(end_of_string),
		.full         (full),
		.push         (push)
	);

	kcc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.category (category)
	);

endmodule

### design/kcc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcc_checker
// Port-level checks on the keyword category classifier.
// ----------------------------------------------------------------------------
module kcc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       is_instrument,
	input logic       end_of_string,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] category
);
	import kcc_pkg::*;

	logic in_take;
	assign in_take = in_valid && !in_stall;

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(category))
	else $error("result changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> category <= CAT_OTHER)
	else $error("category code out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_take && end_of_string))
	else $error("result without a final byte");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_take && is_instrument && end_of_string && !out_valid
		|=> out_valid && category == CAT_INSTRUMENT)
	else $error("instrument flag not honoured");

	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
	else $error("input stalled with empty output");

endmodule

bind keyword_category_classifier_core kcc_checker u_kcc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.is_instrument(is_instrument),
	.end_of_string(end_of_string),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.category     (category)
);

### bench/tb_keyword_category_classifier_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyword_category_classifier_core
// Self-checking bench for the keyword category classifier core.
// Text strings are sent one byte per transaction. A predictor built into the
// bench folds the case of each byte, matches the recent bytes against its own
// keyword list and works out the category due on each final byte. Each
// category taken from the output is checked against the oldest one still
// due. Both sides idle at random, and the output is held off once for a
// long stretch so that the core fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb_keyword_category_classifier_core;

	localparam int WINDOW       = 10;
	localparam int KW_TOTAL     = 26;
	localparam int FILLER_TOTAL = 10;
	localparam int IDLE_PERCENT = 19;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_BYTES = 550;
	localparam int RANDOM_MIN_STRINGS = 30;

	localparam logic [2:0] CAT_INST       = kcc_pkg::CAT_INSTRUMENT;
	localparam logic [2:0] CAT_DELAY      = 3'd1;
	localparam logic [2:0] CAT_DISTORTION = 3'd2;
	localparam logic [2:0] CAT_DYNAMICS   = 3'd3;
	localparam logic [2:0] CAT_EQ         = 3'd4;
	localparam logic [2:0] CAT_MODULATION = 3'd5;
	localparam logic [2:0] CAT_OTH        = kcc_pkg::CAT_OTHER;

	localparam int NO_FLAG = -1;

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       in_valid      = 1'b0;
	logic       in_stall;
	logic [7:0] char_byte     = 8'h00;
	logic       is_instrument = 1'b0;
	logic       end_of_string = 1'b0;
	logic       out_valid;
	logic       out_stall     = 1'b0;
	logic [2:0] category;

	string kw_words [KW_TOTAL] = '{
		"instrument", "generator", "synth", "sampler",
		"delay", "reverb", "echo",
		"distortion", "guitar", "bass", "drive", "saturat", "amp",
		"dynamics", "compressor", "comp", "limiter", "gate",
		"eq", "filter", "equalizer",
		"modulation", "chorus", "flanger", "phaser", "tremolo"
	};

	logic [2:0] kw_groups [KW_TOTAL] = '{
		CAT_INST, CAT_INST, CAT_INST, CAT_INST,
		CAT_DELAY, CAT_DELAY, CAT_DELAY,
		CAT_DISTORTION, CAT_DISTORTION, CAT_DISTORTION, CAT_DISTORTION,
		CAT_DISTORTION, CAT_DISTORTION,
		CAT_DYNAMICS, CAT_DYNAMICS, CAT_DYNAMICS, CAT_DYNAMICS, CAT_DYNAMICS,
		CAT_EQ, CAT_EQ, CAT_EQ,
		CAT_MODULATION, CAT_MODULATION, CAT_MODULATION, CAT_MODULATION,
		CAT_MODULATION
	};

	string filler_words [FILLER_TOTAL] = '{
		"fx", "tools", "spatial", "pitch", "misc",
		"analyzer", "mastering", "surround", "restoration", "network"
	};

	// predictor state
	kcc_pkg::byte_t seen_window [WINDOW-1] = '{default: 8'h00};
	logic [5:0]     group_seen = '0;
	logic           inst_seen  = 1'b0;
	logic [2:0]     expected_categories [$];

	logic [2:0]  oldest_category;
	int unsigned error_count   = 0;
	int unsigned cycle_count   = 0;
	int unsigned bytes_sent    = 0;
	int unsigned strings_sent  = 0;
	bit          idle_on       = 1'b1;
	int unsigned hold_requests = 0;
	int unsigned holds_served  = 0;
	int unsigned hold_left     = 0;

	keyword_category_classifier_core #(
		.MATCH_WINDOW(WINDOW)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.char_byte    (char_byte),
		.is_instrument(is_instrument),
		.end_of_string(end_of_string),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.category     (category)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("keyword_category_classifier_core test failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		$display("mismatch at cycle %0d: %s", cycle_count, what);
		error_count++;
	endtask

	// folds, matches and updates the hit flags; queues a category on the final byte
	function automatic void predict_byte(input kcc_pkg::byte_t raw, input logic inst,
		input logic last);
		kcc_pkg::byte_t recent [WINDOW];
		string          w;
		int             n;
		logic           hit;
		logic [2:0]     cat;
		recent[0] = (raw >= "A" && raw <= "Z") ? raw + 8'd32 : raw;
		for (int i = 1; i < WINDOW; i++) begin
			recent[i] = seen_window[i-1];
		end
		for (int k = 0; k < KW_TOTAL; k++) begin
			w   = kw_words[k];
			n   = w.len();
			hit = (n <= WINDOW);
			for (int i = 0; i < n && hit; i++) begin
				if (recent[i] != kcc_pkg::byte_t'(w[n-1-i])) begin
					hit = 1'b0;
				end
			end
			if (hit) begin
				group_seen[kw_groups[k]] = 1'b1;
			end
		end
		inst_seen = inst_seen | inst;
		for (int i = 0; i < WINDOW - 1; i++) begin
			seen_window[i] = recent[i];
		end
		if (last) begin
			cat = CAT_OTH;
			for (int g = CAT_MODULATION; g >= CAT_DELAY; g--) begin
				if (group_seen[g]) begin
					cat = 3'(g);
				end
			end
			if (inst_seen || group_seen[CAT_INST]) begin
				cat = CAT_INST;
			end
			expected_categories.push_back(cat);
			seen_window = '{default: 8'h00};
			group_seen  = '0;
			inst_seen   = 1'b0;
		end
	endfunction

	// one input transaction; returns at the edge where it is taken
	task automatic send_item(input kcc_pkg::byte_t b, input logic inst, input logic last);
		while (idle_on && ($urandom_range(99) < IDLE_PERCENT)) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		char_byte     <= b;
		is_instrument <= inst;
		end_of_string <= last;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		predict_byte(b, inst, last);
		bytes_sent++;
	endtask

	task automatic send_bytes(input kcc_pkg::byte_t txt [$], input int inst_pos);
		for (int i = 0; i < txt.size(); i++) begin
			send_item(txt[i], i == inst_pos, i == txt.size() - 1);
		end
		strings_sent++;
	endtask

	task automatic send_text(input string s, input int inst_pos);
		kcc_pkg::byte_t txt [$];
		for (int i = 0; i < s.len(); i++) begin
			txt.push_back(kcc_pkg::byte_t'(s[i]));
		end
		send_bytes(txt, inst_pos);
	endtask

	function automatic string random_word();
		string w;
		int    pick;
		pick = $urandom_range(9);
		if (pick <= 5) begin
			w = kw_words[$urandom_range(KW_TOTAL - 1)];
		end else if (pick <= 8) begin
			w = filler_words[$urandom_range(FILLER_TOTAL - 1)];
		end else begin
			w = kw_words[$urandom_range(KW_TOTAL - 1)];
			w = w.substr(0, w.len() - 2);
		end
		for (int i = 0; i < w.len(); i++) begin
			if (w[i] >= "a" && w[i] <= "z" && $urandom_range(1)) begin
				w[i] = w[i] - 8'd32;
			end
		end
		return w;
	endfunction

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_categories.size() == 0) begin
				report_mismatch($sformatf("category %0d with none due", category));
			end else begin
				oldest_category = expected_categories.pop_front();
				if (category !== oldest_category) begin
					report_mismatch($sformatf("category %0d, expected %0d",
						category, oldest_category));
				end
			end
		end
	end

	// output stall: random idling, or a long hold-off when requested
	always @(posedge clk) begin
		if (holds_served != hold_requests) begin
			holds_served = hold_requests;
			hold_left    = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (idle_on) begin
			out_stall <= ($urandom_range(99) < IDLE_PERCENT);
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic test_single_byte_strings();
		send_item(8'h00, 1'b0, 1'b1);
		strings_sent++;
		send_item(8'hFF, 1'b1, 1'b1);
		strings_sent++;
	endtask

	task automatic test_case_folding();
		kcc_pkg::byte_t high_a [$];
		high_a = '{8'hC1, "m", "p"};
		send_text("@AMP[", NO_FLAG);
		send_bytes(high_a, NO_FLAG);
		send_text("`Eq{", NO_FLAG);
	endtask

	task automatic test_priority();
		send_text("gate echo", NO_FLAG);
		send_text("Synth", NO_FLAG);
		send_text("phaser eq", 2);
	endtask

	task automatic test_string_boundary();
		send_text("e", NO_FLAG);
		send_text("q", NO_FLAG);
	endtask

	task automatic test_back_pressure();
		hold_requests++;
		in_valid <= 1'b0;
		@(posedge clk);
		for (int i = 0; i < 20; i++) begin
			send_text(random_word(), NO_FLAG);
		end
	endtask

	task automatic test_random_strings();
		kcc_pkg::byte_t noise [$];
		string          s;
		int unsigned    first_byte;
		int unsigned    first_string;
		int             words;
		first_byte   = bytes_sent;
		first_string = strings_sent;
		while (bytes_sent - first_byte < RANDOM_BYTES
			|| strings_sent - first_string < RANDOM_MIN_STRINGS) begin
			idle_on = !((bytes_sent - first_byte >= 300) && (bytes_sent - first_byte < 450));
			if ($urandom_range(99) < 80) begin
				s     = random_word();
				words = $urandom_range(2, 1);
				for (int i = 0; i < words; i++) begin
					s = {s, " ", random_word()};
				end
				if ($urandom_range(9) == 0) begin
					s = {"x", s};
				end
				send_text(s, ($urandom_range(9) == 0) ? $urandom_range(s.len() - 1) : NO_FLAG);
			end else begin
				noise.delete();
				repeat ($urandom_range(12, 1)) begin
					noise.push_back(8'($urandom_range(255)));
				end
				send_bytes(noise, ($urandom_range(4) == 0) ?
					$urandom_range(noise.size() - 1) : NO_FLAG);
			end
		end
		idle_on = 1'b1;
	endtask

	task automatic finish_run();
		in_valid <= 1'b0;
		while (expected_categories.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("keyword_category_classifier_core test passed");
		end else begin
			$display("keyword_category_classifier_core test failed");
		end
		$finish;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_single_byte_strings();
		test_case_folding();
		test_priority();
		test_string_boundary();
		test_back_pressure();
		test_random_strings();
		finish_run();
	end

endmodule
